// File: rtl/core/cbz_pkg.sv
`timescale 1ns / 1ps

package cbz_pkg;

    // Q16.16 coordinates, Q1.16 curve parameter
    localparam int COORD_W   = 32;
    localparam int T_W       = 17;
    localparam int FRAC_W    = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = DIFF_W + T_W + 1;
    localparam int NSTG      = 9;
    localparam int REG_IDX_W = 3;
    localparam int RND_HALF  = 1 << (FRAC_W - 1);

    localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_W);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_START_X  = 3'd0,
        REG_START_Y  = 3'd1,
        REG_CTRL_A_X = 3'd2,
        REG_CTRL_A_Y = 3'd3,
        REG_CTRL_B_X = 3'd4,
        REG_CTRL_B_Y = 3'd5,
        REG_END_X    = 3'd6,
        REG_END_Y    = 3'd7
    } t_reg_idx;

    // Stage load enables and the curve parameter at each multiply stage
    typedef struct packed {
        logic [NSTG-1:0] ld;
        logic [T_W-1:0]  t_l1;
        logic [T_W-1:0]  t_l2;
        logic [T_W-1:0]  t_l3;
    } t_cbz_ctl;

endpackage

// File: rtl/core/cbz_axis.sv
`timescale 1ns / 1ps

module cbz_axis (
    input  logic                                 i_clk,
    input  logic signed [cbz_pkg::COORD_W-1:0]   i_p0,
    input  logic signed [cbz_pkg::COORD_W-1:0]   i_p1,
    input  logic signed [cbz_pkg::COORD_W-1:0]   i_p2,
    input  logic signed [cbz_pkg::COORD_W-1:0]   i_p3,
    input  cbz_pkg::t_cbz_ctl                    i_ctl,
    output logic signed [cbz_pkg::COORD_W-1:0]   o_point,
    output logic signed [cbz_pkg::COORD_W-1:0]   o_tangent
);
    import cbz_pkg::*;

    function automatic logic signed [DIFF_W-1:0] f_diff(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] q
    );
        return $signed({q[COORD_W-1], q}) - $signed({p[COORD_W-1], p});
    endfunction

    // base + round_half_up(prod / 2^16); result is known to fit 32 bits
    function automatic logic signed [COORD_W-1:0] f_round_add(
        input logic signed [COORD_W-1:0] base,
        input logic signed [PROD_W-1:0]  prod
    );
        logic signed [PROD_W-1:0] rnd;
        rnd = prod + $signed(PROD_W'(RND_HALF));
        rnd = rnd >>> FRAC_W;
        return base + $signed(rnd[COORD_W-1:0]);
    endfunction

    function automatic logic signed [COORD_W-1:0] f_sat_x3(
        input logic signed [DIFF_W-1:0] d
    );
        logic signed [DIFF_W+1:0] x3;
        x3 = $signed({d, 1'b0}) + $signed({{2{d[DIFF_W-1]}}, d});
        if (x3[DIFF_W+1:COORD_W-1] == '0 || x3[DIFF_W+1:COORD_W-1] == '1) begin
            return x3[COORD_W-1:0];
        end
        return x3[DIFF_W+1] ? {1'b1, {(COORD_W-1){1'b0}}}
                            : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    // level 1
    logic signed [DIFF_W-1:0]  r_d01, r_d12, r_d23;
    logic signed [PROD_W-1:0]  r_m0, r_m1, r_m2;
    logic signed [COORD_W-1:0] r_a, r_b, r_c;
    // level 2
    logic signed [DIFF_W-1:0]  r_dab, r_dbc;
    logic signed [COORD_W-1:0] r_a4, r_b4;
    logic signed [PROD_W-1:0]  r_m3, r_m4;
    logic signed [COORD_W-1:0] r_a5, r_b5;
    logic signed [COORD_W-1:0] r_d, r_e;
    // level 3
    logic signed [DIFF_W-1:0]  r_dde;
    logic signed [COORD_W-1:0] r_d7;
    logic signed [PROD_W-1:0]  r_m5;
    logic signed [COORD_W-1:0] r_d8, r_tan8;
    logic signed [COORD_W-1:0] r_pt, r_tan;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_d01 <= f_diff(i_p0, i_p1);
            r_d12 <= f_diff(i_p1, i_p2);
            r_d23 <= f_diff(i_p2, i_p3);
        end
        if (i_ctl.ld[1]) begin
            r_m0 <= r_d01 * $signed({1'b0, i_ctl.t_l1});
            r_m1 <= r_d12 * $signed({1'b0, i_ctl.t_l1});
            r_m2 <= r_d23 * $signed({1'b0, i_ctl.t_l1});
        end
        if (i_ctl.ld[2]) begin
            r_a <= f_round_add(i_p0, r_m0);
            r_b <= f_round_add(i_p1, r_m1);
            r_c <= f_round_add(i_p2, r_m2);
        end
        if (i_ctl.ld[3]) begin
            r_dab <= f_diff(r_a, r_b);
            r_dbc <= f_diff(r_b, r_c);
            r_a4  <= r_a;
            r_b4  <= r_b;
        end
        if (i_ctl.ld[4]) begin
            r_m3 <= r_dab * $signed({1'b0, i_ctl.t_l2});
            r_m4 <= r_dbc * $signed({1'b0, i_ctl.t_l2});
            r_a5 <= r_a4;
            r_b5 <= r_b4;
        end
        if (i_ctl.ld[5]) begin
            r_d <= f_round_add(r_a5, r_m3);
            r_e <= f_round_add(r_b5, r_m4);
        end
        if (i_ctl.ld[6]) begin
            r_dde <= f_diff(r_d, r_e);
            r_d7  <= r_d;
        end
        if (i_ctl.ld[7]) begin
            r_m5   <= r_dde * $signed({1'b0, i_ctl.t_l3});
            r_d8   <= r_d7;
            r_tan8 <= f_sat_x3(r_dde);
        end
        if (i_ctl.ld[8]) begin
            r_pt  <= f_round_add(r_d8, r_m5);
            r_tan <= r_tan8;
        end
    end

    assign o_point   = r_pt;
    assign o_tangent = r_tan;

endmodule

// File: rtl/core/cubic_bezier_point_and_tangent.sv
`timescale 1ns / 1ps
// Cubic Bezier point and tangent evaluator. Load the four control points
// (signed Q16.16) through the write port while no item is in flight, then
// issue one curve parameter t (unsigned Q1.16, 65536 = 1.0, larger values
// clamp to 1.0) per cycle with i_start. Each item comes back, marked by
// a one-cycle o_valid pulse, in issue order: one item per clock sustained.
// The pipeline is built from the three de Casteljau levels, each cut into
// subtract, multiply and round stages around 33x18 multipliers in each
// axis lane. The receiver cannot stall the outputs, so capture them on
// o_valid. o_busy is high only during reset and the cycle after; outside
// that, every start is accepted. The tangent is 3*(e - d) from the two
// second-level points, saturated to 32 bits.

module cubic_bezier_point_and_tangent (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [cbz_pkg::REG_IDX_W-1:0]         i_cfg_idx,
    input  logic [cbz_pkg::COORD_W-1:0]           i_cfg_data,
    // item in
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [cbz_pkg::T_W-1:0]               i_t_param,
    // item out
    output logic                                  o_valid,
    output logic signed [cbz_pkg::COORD_W-1:0]    o_point_x,
    output logic signed [cbz_pkg::COORD_W-1:0]    o_point_y,
    output logic signed [cbz_pkg::COORD_W-1:0]    o_tangent_x,
    output logic signed [cbz_pkg::COORD_W-1:0]    o_tangent_y
);
    import cbz_pkg::*;

    logic signed [COORD_W-1:0] r_start_x, r_start_y, r_ctrl_a_x, r_ctrl_a_y;
    logic signed [COORD_W-1:0] r_ctrl_b_x, r_ctrl_b_y, r_end_x, r_end_y;

    logic                r_busy;
    logic                w_acc;
    logic [T_W-1:0]      w_t_sat;
    logic [NSTG-1:0]     r_vld;
    logic [T_W-1:0]      r_tp [0:6];
    t_cbz_ctl            w_ctl;

    // Hold the control points; the user must write them only while the pipe is empty, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_ctrl_a_x <= '0;
            r_ctrl_a_y <= '0;
            r_ctrl_b_x <= '0;
            r_ctrl_b_y <= '0;
            r_end_x    <= '0;
            r_end_y    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_START_X:  r_start_x  <= i_cfg_data;
                REG_START_Y:  r_start_y  <= i_cfg_data;
                REG_CTRL_A_X: r_ctrl_a_x <= i_cfg_data;
                REG_CTRL_A_Y: r_ctrl_a_y <= i_cfg_data;
                REG_CTRL_B_X: r_ctrl_b_x <= i_cfg_data;
                REG_CTRL_B_Y: r_ctrl_b_y <= i_cfg_data;
                REG_END_X:    r_end_x    <= i_cfg_data;
                REG_END_Y:    r_end_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Busy only while coming out of reset; the pipe never backs up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy  = r_busy;
    assign w_acc   = i_start && !r_busy;
    // Clamp t above one to exactly one.
    assign w_t_sat = (i_t_param > T_ONE) ? T_ONE : i_t_param;

    // Advance the valid bits with the data, one per stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], w_acc};
        end
    end

    // Carry t alongside the item up to the last multiply stage.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_tp[0] <= w_t_sat;
        end
        for (int k = 1; k < 7; k++) begin
            if (r_vld[k-1]) begin
                r_tp[k] <= r_tp[k-1];
            end
        end
    end

    assign w_ctl.ld   = {r_vld[NSTG-2:0], w_acc};
    assign w_ctl.t_l1 = r_tp[0];
    assign w_ctl.t_l2 = r_tp[3];
    assign w_ctl.t_l3 = r_tp[6];

    cbz_axis u_axis_x (
        .i_clk     (i_clk),
        .i_p0      (r_start_x),
        .i_p1      (r_ctrl_a_x),
        .i_p2      (r_ctrl_b_x),
        .i_p3      (r_end_x),
        .i_ctl     (w_ctl),
        .o_point   (o_point_x),
        .o_tangent (o_tangent_x)
    );

    cbz_axis u_axis_y (
        .i_clk     (i_clk),
        .i_p0      (r_start_y),
        .i_p1      (r_ctrl_a_y),
        .i_p2      (r_ctrl_b_y),
        .i_p3      (r_end_y),
        .i_ctl     (w_ctl),
        .o_point   (o_point_y),
        .o_tangent (o_tangent_y)
    );

    assign o_valid = r_vld[NSTG-1];

endmodule

// File: rtl/core/cbz_chk.sv
`timescale 1ns / 1ps

module cbz_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          i_busy,
    input logic                          i_valid
);
    import cbz_pkg::*;

    // Every accepted item comes out exactly once, and every result strobe matches an accepted item.
    a_acc_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |-> ##NSTG i_valid)
        else $error("accepted item did not come out on time");

    a_out_from_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> $past(i_start && !i_busy, NSTG))
        else $error("result strobe without a matching accepted item");

    // Reset flushes the pipe and raises busy to block new items.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_busy && !i_valid))
        else $error("pipe not flushed by reset");

endmodule

bind cubic_bezier_point_and_tangent cbz_chk u_cbz_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_busy  (o_busy),
    .i_valid (o_valid)
);

// File: tb/cubic_bezier_point_and_tangent_tb.sv
`timescale 1ns / 1ps

module cubic_bezier_point_and_tangent_tb;

    import cbz_pkg::*;

    localparam longint COORD_MAX       = 64'sd2147483647;
    localparam longint COORD_MIN       = -64'sd2147483648;
    localparam int     N_PHASES        = 11;
    localparam int     ITEMS_PER_PHASE = 140;
    localparam int     CYCLE_LIMIT     = 400000;

    // how the control points of a phase are drawn
    localparam int CS_FULL   = 0;   // anywhere in the 32-bit range
    localparam int CS_NEAR   = 1;   // within +-16.0 of the origin
    localparam int CS_CORNER = 2;   // range limits and a few landmarks
    localparam int CS_MIXED  = 3;   // a different style per register

    typedef struct {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
    } t_curve_sample;

    // Holds a private copy of the control points and the samples still owed
    // by the pipeline, oldest first.
    class curve_scoreboard;
        longint        ctrl_pt[8];
        t_curve_sample expected_q[$];
        int            errors;
        int            n_items;
        int            n_results;
        int            n_clamped_t;
        int            n_sat_tan;

        function new();
            foreach (ctrl_pt[i]) ctrl_pt[i] = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [COORD_W-1:0] value);
            ctrl_pt[idx] = longint'($signed(value));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one de Casteljau step, round half up; >>> floors a negative sum
        static function longint blend(longint p, longint q, longint t);
            return (p * (longint'(T_ONE) - t) + q * t + longint'(RND_HALF)) >>> FRAC_W;
        endfunction

        static function logic signed [COORD_W-1:0] clamp32(longint v);
            if (v > COORD_MAX) return COORD_W'(COORD_MAX);
            if (v < COORD_MIN) return COORD_W'(COORD_MIN);
            return COORD_W'(v);
        endfunction

        function void eval_axis(longint p0, longint p1, longint p2, longint p3, longint t,
                                output logic signed [COORD_W-1:0] pt,
                                output logic signed [COORD_W-1:0] slope);
            longint a, b, c, d, e, dt;
            a = blend(p0, p1, t);
            b = blend(p1, p2, t);
            c = blend(p2, p3, t);
            d = blend(a, b, t);
            e = blend(b, c, t);
            dt = 3 * (e - d);
            if (dt > COORD_MAX || dt < COORD_MIN) n_sat_tan++;
            pt = clamp32(blend(d, e, t));
            slope = clamp32(dt);
        endfunction

        function void note_item(logic [T_W-1:0] t_raw);
            longint        t;
            t_curve_sample s;
            if (t_raw > T_ONE) n_clamped_t++;
            t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
            eval_axis(ctrl_pt[REG_START_X], ctrl_pt[REG_CTRL_A_X], ctrl_pt[REG_CTRL_B_X],
                      ctrl_pt[REG_END_X], t, s.px, s.tx);
            eval_axis(ctrl_pt[REG_START_Y], ctrl_pt[REG_CTRL_A_Y], ctrl_pt[REG_CTRL_B_Y],
                      ctrl_pt[REG_END_Y], t, s.py, s.ty);
            expected_q.push_back(s);
            n_items++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] ERROR: %s", $time, msg);
        endtask

        task check_result(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                          logic signed [COORD_W-1:0] tx, logic signed [COORD_W-1:0] ty);
            t_curve_sample want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: pt=(%h,%h) tan=(%h,%h)",
                                          px, py, tx, ty));
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            if (px !== want.px)
                report_mismatch($sformatf("point_x got %h want %h", px, want.px));
            if (py !== want.py)
                report_mismatch($sformatf("point_y got %h want %h", py, want.py));
            if (tx !== want.tx)
                report_mismatch($sformatf("tangent_x got %h want %h", tx, want.tx));
            if (ty !== want.ty)
                report_mismatch($sformatf("tangent_y got %h want %h", ty, want.ty));
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [REG_IDX_W-1:0]       i_cfg_idx;
    logic [COORD_W-1:0]         i_cfg_data;
    logic                       i_start;
    logic                       o_busy;
    logic [T_W-1:0]             i_t_param;
    logic                       o_valid;
    logic signed [COORD_W-1:0]  o_point_x;
    logic signed [COORD_W-1:0]  o_point_y;
    logic signed [COORD_W-1:0]  o_tangent_x;
    logic signed [COORD_W-1:0]  o_tangent_y;

    curve_scoreboard sb = new();
    int              cycles = 0;

    cubic_bezier_point_and_tangent dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_t_param   (i_t_param),
        .o_valid     (o_valid),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_tangent_x (o_tangent_x),
        .o_tangent_y (o_tangent_y)
    );

    always #4 i_clk = ~i_clk;

    // Capture every strobed result; values read here are those held before
    // the edge, since the block updates its outputs after it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_result(o_point_x, o_point_y, o_tangent_x, o_tangent_y);
    end

    // Watchdog: a hung pipeline or a stuck busy ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[%0t] ERROR: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Write all eight control-point registers on consecutive edges. Call
    // only with the pipeline empty; write enable drops once at the end.
    task automatic load_curve(input logic [7:0][COORD_W-1:0] pts);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_IDX_W'(i);
            i_cfg_data <= pts[i];
            sb.set_reg(t_reg_idx'(i), pts[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offer one item, optionally after an idle burst, and hold it until it
    // is taken. Start stays high on return so back-to-back items stream.
    task automatic send_item(input logic [T_W-1:0] t, input int gap_pct);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_t_param <= t;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(t);
    endtask

    // Drop start and wait for every outstanding sample, then let the
    // pipeline settle a little before the next register write.
    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (NSTG + 2) @(posedge i_clk);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(int style);
        case (style)
            CS_FULL: return $urandom;
            CS_NEAR: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    4:       return 32'h0001_0000;
                    default: return 32'h0000_0001;
                endcase
            end
        endcase
    endfunction

    // Mostly legal parameters, with the ends of the range and values above
    // one (which clamp to one) mixed in.
    function automatic logic [T_W-1:0] rand_t();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)  return ($urandom_range(0, 1) != 0) ? T_ONE : T_W'(0);
        if (r < 14) return T_W'($urandom_range(int'(T_ONE) + 1, (1 << T_W) - 1));
        if (r < 18) return T_W'($urandom_range(0, 3));
        if (r < 22) return T_W'($urandom_range(int'(T_ONE) - 3, int'(T_ONE)));
        return T_W'($urandom_range(0, int'(T_ONE)));
    endfunction

    initial begin
        logic [7:0][COORD_W-1:0] cp;
        logic [T_W-1:0]          sweep[8];
        int                      style;
        int                      gap_pct;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        i_start    <= 1'b0;
        i_t_param  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (o_busy);

        // ends, midpoint, one step in from each end, and above-one values
        sweep = '{T_W'(0), T_W'(1), T_W'(32768), T_W'(65535), T_ONE,
                  T_W'(65537), T_W'(98304), T_W'((1 << T_W) - 1)};

        // Reset leaves every control point at the origin.
        send_item(T_W'((1 << T_W) - 1), 0);
        send_item(T_W'(0), 0);
        drain();

        // All points at the positive limit: every level stays at the limit.
        cp = {8{32'h7FFF_FFFF}};
        load_curve(cp);
        foreach (sweep[k]) send_item(sweep[k], 0);
        drain();

        // Points swing between the limits on alternate control points, with
        // y mirrored against x: the tangent saturates both ways.
        for (int i = 0; i < 8; i++)
            cp[i] = (((i / 2) % 2) == (i % 2)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        load_curve(cp);
        foreach (sweep[k]) send_item(sweep[k], 0);
        drain();

        // All points at the negative limit.
        cp = {8{32'h8000_0000}};
        load_curve(cp);
        send_item(T_W'(0), 0);
        send_item(T_W'(32768), 0);
        send_item(T_ONE, 0);
        send_item(T_W'((1 << T_W) - 1), 0);
        drain();

        // Random curves. Idling varies by phase; some phases and the last
        // one stream without gaps.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            style = ph % 4;
            if (ph == N_PHASES - 1 || ph % 3 == 0) gap_pct = 0;
            else if (ph % 3 == 1)                  gap_pct = 20;
            else                                   gap_pct = 50;
            for (int i = 0; i < 8; i++)
                cp[i] = rand_coord(style == CS_MIXED ? $urandom_range(CS_FULL, CS_CORNER)
                                                     : style);
            load_curve(cp);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(rand_t(), gap_pct);
            drain();
        end

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d samples never returned", sb.pending()));

        $display("Evaluated %0d parameters over %0d curves, %0d results checked.",
                 sb.n_items, N_PHASES + 4, sb.n_results);
        $display("%0d parameters clamped to one, %0d tangent components saturated, %0d errors.",
                 sb.n_clamped_t, sb.n_sat_tan, sb.errors);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: cubic_bezier_point_and_tangent.f
rtl/core/cbz_pkg.sv
rtl/core/cbz_axis.sv
rtl/core/cubic_bezier_point_and_tangent.sv
rtl/core/cbz_chk.sv
tb/cubic_bezier_point_and_tangent_tb.sv
